FILE: design/aarm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types and constants for the axis-angle rotation matrix pipeline.
// ----------------------------------------------------------------------------
package aarm_pkg;

  // input and result words
  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [19:0] angle_deg;
  } item_t;

  typedef struct packed {
    logic signed [15:0] row0_col0;
    logic signed [15:0] row0_col1;
    logic signed [15:0] row0_col2;
    logic signed [15:0] row1_col0;
    logic signed [15:0] row1_col1;
    logic signed [15:0] row1_col2;
    logic signed [15:0] row2_col0;
    logic signed [15:0] row2_col1;
    logic signed [15:0] row2_col2;
    logic               axis_is_zero;
  } result_t;

  // cordic datapath, q2.30 with headroom
  localparam int CW = 34;
  localparam int MAX_STAGES = 24;
  typedef logic signed [CW-1:0] cw_t;
  localparam cw_t KINV = 34'sd652032874;
  localparam cw_t ONE_Q = 34'sd1073741824;

  typedef struct packed {
    cw_t  x;
    cw_t  y;
    cw_t  z;
    logic flip;
  } cordic_t;

  // integer square root cells
  localparam int SQW = 64;
  localparam int SQ_CELLS = 31;

  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW-1:0] res;
  } sqrt_t;

  // restoring divider cells
  localparam int NW = 62;
  localparam int DW = 32;
  localparam int QW = 31;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
    logic          neg;
  } div_t;

  // atan(2^-i) in q2.30, truncated
  function automatic cw_t atan_q(input int idx);
    cw_t a;
    case (idx)
      0:  a = 34'sd843314856;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043836;
      3:  a = 34'sd133525158;
      4:  a = 34'sd67021686;
      5:  a = 34'sd33543515;
      6:  a = 34'sd16775850;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194282;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      16: a = 34'sd16383;
      17: a = 34'sd8191;
      18: a = 34'sd4095;
      19: a = 34'sd2047;
      20: a = 34'sd1023;
      21: a = 34'sd511;
      22: a = 34'sd255;
      23: a = 34'sd127;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: design/aarm_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_cordic_cell
// One rotation-mode cordic micro-rotation, registered.
// ----------------------------------------------------------------------------
module aarm_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              en,
  input  aarm_pkg::cordic_t prev,
  output aarm_pkg::cordic_t cur
);

  localparam aarm_pkg::cw_t ATAN = aarm_pkg::atan_q(IDX);

  aarm_pkg::cordic_t cur_next;

  always_comb begin
    cur_next = prev;
    if (!prev.z[aarm_pkg::CW-1]) begin
      cur_next.x = prev.x - ($signed(prev.y) >>> IDX);
      cur_next.y = prev.y + ($signed(prev.x) >>> IDX);
      cur_next.z = prev.z - ATAN;
    end else begin
      cur_next.x = prev.x + ($signed(prev.y) >>> IDX);
      cur_next.y = prev.y - ($signed(prev.x) >>> IDX);
      cur_next.z = prev.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur <= cur_next;
    end
  end

endmodule

FILE: design/aarm_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_sqrt_cell
// One digit of the bit-pair integer square root, registered.
// ----------------------------------------------------------------------------
module aarm_sqrt_cell #(
  parameter int POS = 0
) (
  input  logic            clk,
  input  logic            en,
  input  aarm_pkg::sqrt_t prev,
  output aarm_pkg::sqrt_t cur
);

  localparam int W = aarm_pkg::SQW;
  localparam logic [W-1:0] BITV = {{(W-1){1'b0}}, 1'b1} << POS;

  aarm_pkg::sqrt_t cur_next;
  logic [W-1:0]    trial;

  always_comb begin
    trial    = prev.res + BITV;
    cur_next = prev;
    if (prev.v >= trial) begin
      cur_next.v   = prev.v - trial;
      cur_next.res = (prev.res >> 1) + BITV;
    end else begin
      cur_next.res = prev.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur <= cur_next;
    end
  end

endmodule

FILE: design/aarm_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_div_cell
// One quotient bit of a restoring divider, registered.
// ----------------------------------------------------------------------------
module aarm_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  aarm_pkg::div_t prev,
  output aarm_pkg::div_t cur
);

  localparam int NW = aarm_pkg::NW;
  localparam int DW = aarm_pkg::DW;

  aarm_pkg::div_t cur_next;
  logic [NW-1:0]  shifted;

  always_comb begin
    shifted  = {{(NW-DW){1'b0}}, prev.den} << BIT;
    cur_next = prev;
    if (prev.rem >= shifted) begin
      cur_next.rem      = prev.rem - shifted;
      cur_next.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur <= cur_next;
    end
  end

endmodule

FILE: design/axis_angle_rotation_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rodrigues rotation matrix from an integer axis and an angle in 1/256 degree.
// ----------------------------------------------------------------------------
// Takes one word per cycle while item_stall is low. The axis path is the
// longest: a 31-cell square root chain followed by 31-cell divider chains
// (one bit per cell) for the normalized axis; the angle wrap and cordic
// chain run beside it and are delayed to line up. The whole pipeline
// advances together, so a held result stalls the input side until it is
// taken. A zero axis sets axis_is_zero and returns identity.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  aarm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output aarm_pkg::result_t result
);

  localparam int CS  = (CORDIC_STAGES > aarm_pkg::MAX_STAGES) ?
                       aarm_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int DCS = 59 - CS;
  localparam int LAT = 69;
  localparam int SH  = 30 - FRAC_BITS;

  typedef logic signed [39:0] rt_t;
  typedef logic signed [31:0] qs_t;
  typedef logic signed [32:0] us_t;
  typedef logic signed [67:0] pr_t;

  typedef struct packed {
    logic [5:0][aarm_pkg::QW-1:0] mag;
    logic [5:0]                   neg;
    logic                         zero;
  } qpack_t;

  function automatic logic signed [37:0] rnd30(input pr_t v);
    pr_t w;
    w = (v + (68'sd1 <<< 29)) >>> 30;
    return w[37:0];
  endfunction

  function automatic logic signed [15:0] emit(input rt_t v);
    rt_t w;
    rt_t lim;
    lim = 40'sd1 <<< FRAC_BITS;
    w   = (v + (40'sd1 <<< (SH - 1))) >>> SH;
    if (w > lim) w = lim;
    if (w < -lim) w = -lim;
    if (w > 40'sd32767) w = 40'sd32767;
    if (w < -40'sd32768) w = -40'sd32768;
    return w[15:0];
  endfunction

  logic           en;
  logic [LAT-1:0] vld;

  assign en           = !(vld[LAT-1] && result_stall);
  assign item_stall   = !en;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  // stage 0: input word
  aarm_pkg::item_t it0;
  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= item;
    end
  end

  // ---------------- angle path ----------------
  // stage 1: offset to positive, estimate turns by reciprocal
  logic [20:0] wv0;
  logic [41:0] tprod;
  logic [20:0] wv1;
  logic [3:0]  qe1;

  assign wv0   = 21'(it0.angle_deg) + 21'd552960;
  assign tprod = {21'b0, wv0} * 42'd1491308;

  always_ff @(posedge clk) begin
    if (en) begin
      wv1 <= wv0;
      qe1 <= tprod[40:37];
    end
  end

  // stage 2: remainder, fold into -90..90 degrees
  logic [21:0]        ra;
  logic [21:0]        rb;
  logic signed [18:0] ma;
  logic signed [18:0] mb;
  logic               fold;
  logic [14:0]        mmag2;
  logic               msgn2;
  logic               neg2;

  always_comb begin
    ra   = {1'b0, wv1} - (22'(qe1) * 22'd92160);
    rb   = (ra >= 22'd92160) ? ra - 22'd92160 : ra;
    ma   = (rb >= 22'd46080) ? $signed(19'(rb)) - 19'sd92160 : $signed(19'(rb));
    mb   = ma;
    fold = 1'b0;
    if (ma > 19'sd23040) begin
      mb   = ma - 19'sd46080;
      fold = 1'b1;
    end else if (ma < -19'sd23040) begin
      mb   = ma + 19'sd46080;
      fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mmag2 <= 15'(mb[18] ? -mb : mb);
      msgn2 <= mb[18];
      neg2  <= fold;
    end
  end

  // stage 3: m*pi/46080 = 73204*m + (19048*m + half) / 46080
  logic [28:0] na3;
  logic [30:0] base3;
  logic        msgn3;
  logic        neg3;

  always_ff @(posedge clk) begin
    if (en) begin
      na3   <= 29'(mmag2) * 29'd19048 + 29'd23040;
      base3 <= 31'(mmag2) * 31'd73204;
      msgn3 <= msgn2;
      neg3  <= neg2;
    end
  end

  // stage 4: /1024 by shift, /45 by reciprocal estimate
  logic [18:0] w3;
  logic [39:0] dprod;
  logic [18:0] w4;
  logic [13:0] qe4;
  logic [30:0] base4;
  logic        msgn4;
  logic        neg4;

  assign w3    = na3[28:10];
  assign dprod = 40'(w3) * 40'd1491308;

  always_ff @(posedge clk) begin
    if (en) begin
      w4    <= w3;
      qe4   <= dprod[39:26];
      base4 <= base3;
      msgn4 <= msgn3;
      neg4  <= neg3;
    end
  end

  // stage 5: correct estimate, signed radians into cordic
  logic [19:0]       rem4;
  logic [13:0]       qc4;
  logic [30:0]       mag4;
  aarm_pkg::cordic_t cin;

  always_comb begin
    rem4 = 20'(w4) - 20'(qe4) * 20'd45;
    qc4  = (rem4 >= 20'd45) ? qe4 + 14'd1 : qe4;
    mag4 = base4 + 31'(qc4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cin.x    <= aarm_pkg::KINV;
      cin.y    <= '0;
      cin.z    <= msgn4 ? -aarm_pkg::cw_t'(mag4) : aarm_pkg::cw_t'(mag4);
      cin.flip <= neg4;
    end
  end

  // cordic chain
  aarm_pkg::cordic_t cst [0:CS];
  assign cst[0] = cin;

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    aarm_cordic_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .en   (en),
      .prev (cst[i]),
      .cur  (cst[i+1])
    );
  end

  aarm_pkg::cordic_t cdl [1:DCS];
  always_ff @(posedge clk) begin
    if (en) begin
      cdl[1] <= cst[CS];
      for (int k = 2; k <= DCS; k++) begin
        cdl[k] <= cdl[k-1];
      end
    end
  end

  // ---------------- axis path ----------------
  // stage 1: squares and cross products (xx yy zz xy xz yz)
  qs_t pr0 [6];
  qs_t pr1 [6];

  assign pr0[0] = it0.axis_x * it0.axis_x;
  assign pr0[1] = it0.axis_y * it0.axis_y;
  assign pr0[2] = it0.axis_z * it0.axis_z;
  assign pr0[3] = it0.axis_x * it0.axis_y;
  assign pr0[4] = it0.axis_x * it0.axis_z;
  assign pr0[5] = it0.axis_y * it0.axis_z;

  // stage 2: squared length
  qs_t         pr2 [6];
  logic [31:0] l2;

  always_ff @(posedge clk) begin
    if (en) begin
      pr1 <= pr0;
      pr2 <= pr1;
      l2  <= 32'(pr1[0]) + 32'(pr1[1]) + 32'(pr1[2]);
    end
  end

  // axis words carried to the normalizing divide
  aarm_pkg::item_t adl [1:33];
  always_ff @(posedge clk) begin
    if (en) begin
      adl[1] <= it0;
      for (int k = 2; k <= 33; k++) begin
        adl[k] <= adl[k-1];
      end
    end
  end

  // sqrt(l2 * 2^30)
  aarm_pkg::sqrt_t sst [0:aarm_pkg::SQ_CELLS];
  assign sst[0].v   = {2'b00, l2, 30'b0};
  assign sst[0].res = '0;

  for (genvar i = 0; i < aarm_pkg::SQ_CELLS; i++) begin : g_sqrt
    aarm_sqrt_cell #(.POS(60 - 2 * i)) u_cell (
      .clk  (clk),
      .en   (en),
      .prev (sst[i]),
      .cur  (sst[i+1])
    );
  end

  // outer product terms a_j*a_k / l2, rounded
  aarm_pkg::div_t qst [6][0:aarm_pkg::QW];

  for (genvar l = 0; l < 6; l++) begin : g_qlane
    logic [30:0] pmag;
    assign pmag          = 31'(pr2[l][31] ? -pr2[l] : pr2[l]);
    assign qst[l][0].rem = {1'b0, pmag, 30'b0} + {31'b0, l2[31:1]};
    assign qst[l][0].den = l2;
    assign qst[l][0].quo = '0;
    assign qst[l][0].neg = pr2[l][31];

    for (genvar i = 0; i < aarm_pkg::QW; i++) begin : g_cell
      aarm_div_cell #(.BIT(aarm_pkg::QW - 1 - i)) u_cell (
        .clk  (clk),
        .en   (en),
        .prev (qst[l][i]),
        .cur  (qst[l][i+1])
      );
    end
  end

  qpack_t qin;
  qpack_t qdl [1:31];

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      qin.mag[l] = qst[l][aarm_pkg::QW].quo;
      qin.neg[l] = qst[l][aarm_pkg::QW].neg;
    end
    qin.zero = (qst[0][aarm_pkg::QW].den == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qdl[1] <= qin;
      for (int k = 2; k <= 31; k++) begin
        qdl[k] <= qdl[k-1];
      end
    end
  end

  // unit axis a_k * 2^45 / sqrt, rounded
  logic signed [15:0] acomp [3];
  aarm_pkg::div_t     ust [3][0:aarm_pkg::QW];

  assign acomp[0] = adl[33].axis_x;
  assign acomp[1] = adl[33].axis_y;
  assign acomp[2] = adl[33].axis_z;

  for (genvar l = 0; l < 3; l++) begin : g_ulane
    logic [15:0] amag;
    assign amag          = acomp[l][15] ? 16'(-acomp[l]) : 16'(acomp[l]);
    assign ust[l][0].rem = {1'b0, amag, 45'b0} + {32'b0, sst[aarm_pkg::SQ_CELLS].res[30:1]};
    assign ust[l][0].den = {1'b0, sst[aarm_pkg::SQ_CELLS].res[30:0]};
    assign ust[l][0].quo = '0;
    assign ust[l][0].neg = acomp[l][15];

    for (genvar i = 0; i < aarm_pkg::QW; i++) begin : g_cell
      aarm_div_cell #(.BIT(aarm_pkg::QW - 1 - i)) u_cell (
        .clk  (clk),
        .en   (en),
        .prev (ust[l][i]),
        .cur  (ust[l][i+1])
      );
    end
  end

  // ---------------- combine ----------------
  // stage 65: signed terms
  qs_t           q65 [6];
  us_t           u65 [3];
  aarm_pkg::cw_t c65;
  aarm_pkg::cw_t s65;
  logic          zero65;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        q65[l] <= qdl[31].neg[l] ? -qs_t'(qdl[31].mag[l]) : qs_t'(qdl[31].mag[l]);
      end
      for (int l = 0; l < 3; l++) begin
        u65[l] <= ust[l][aarm_pkg::QW].neg ? -us_t'(ust[l][aarm_pkg::QW].quo)
                                           : us_t'(ust[l][aarm_pkg::QW].quo);
      end
      c65    <= cdl[DCS].flip ? -cdl[DCS].x : cdl[DCS].x;
      s65    <= cdl[DCS].flip ? -cdl[DCS].y : cdl[DCS].y;
      zero65 <= qdl[31].zero;
    end
  end

  // stage 66: products
  aarm_pkg::cw_t t65;
  pr_t           pq [6];
  pr_t           pu [3];
  aarm_pkg::cw_t c66;
  logic          zero66;

  assign t65 = aarm_pkg::ONE_Q - c65;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        pq[l] <= pr_t'(t65) * pr_t'(q65[l]);
      end
      for (int l = 0; l < 3; l++) begin
        pu[l] <= pr_t'(s65) * pr_t'(u65[l]);
      end
      c66    <= c65;
      zero66 <= zero65;
    end
  end

  // stage 67: matrix entries in q2.30
  logic signed [37:0] rq [6];
  logic signed [37:0] sv [3];
  rt_t                cc;
  rt_t                rn [9];
  rt_t                r67 [9];
  logic               zero67;

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      rq[l] = rnd30(pq[l]);
    end
    for (int l = 0; l < 3; l++) begin
      sv[l] = rnd30(pu[l]);
    end
    cc    = rt_t'(c66);
    rn[0] = rt_t'(rq[0]) + cc;
    rn[1] = rt_t'(rq[3]) - rt_t'(sv[2]);
    rn[2] = rt_t'(rq[4]) + rt_t'(sv[1]);
    rn[3] = rt_t'(rq[3]) + rt_t'(sv[2]);
    rn[4] = rt_t'(rq[1]) + cc;
    rn[5] = rt_t'(rq[5]) - rt_t'(sv[0]);
    rn[6] = rt_t'(rq[4]) - rt_t'(sv[1]);
    rn[7] = rt_t'(rq[5]) + rt_t'(sv[0]);
    rn[8] = rt_t'(rq[2]) + cc;
    // zero axis gives identity
    if (zero66) begin
      for (int l = 0; l < 9; l++) begin
        rn[l] = '0;
      end
      rn[0] = rt_t'(aarm_pkg::ONE_Q);
      rn[4] = rt_t'(aarm_pkg::ONE_Q);
      rn[8] = rt_t'(aarm_pkg::ONE_Q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r67    <= rn;
      zero67 <= zero66;
    end
  end

  // stage 68: output word
  always_ff @(posedge clk) begin
    if (en) begin
      result.row0_col0    <= emit(r67[0]);
      result.row0_col1    <= emit(r67[1]);
      result.row0_col2    <= emit(r67[2]);
      result.row1_col0    <= emit(r67[3]);
      result.row1_col1    <= emit(r67[4]);
      result.row1_col2    <= emit(r67[5]);
      result.row2_col0    <= emit(r67[6]);
      result.row2_col1    <= emit(r67[7]);
      result.row2_col2    <= emit(r67[8]);
      result.axis_is_zero <= zero67;
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the axis-angle rotation matrix pipeline. A local
// fixed-point model predicts every matrix; results are checked in order while
// both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STAGES = 16;
  localparam int FRAC = 14;
  localparam int LATENCY = 69;
  localparam int N_RANDOM = 1725;
  localparam longint PI_Q30 = 64'sd3373259368;
  localparam longint KINV_Q30 = 64'sd652032874;
  localparam longint ONE_Q30 = 64'sd1073741824;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic result_stall = 1'b0;
  aarm_pkg::item_t item = '0;
  logic item_stall;
  logic result_valid;
  aarm_pkg::result_t result;

  aarm_pkg::result_t matrix_queue[$];
  int n_errors = 0;
  int n_matrices = 0;
  int n_zero_axis = 0;
  bit calm = 1'b0;

  axis_angle_rotation_matrix #(.CORDIC_STAGES(STAGES), .FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
    .item(item), .result_valid(result_valid), .result_stall(result_stall),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic longint atan_entry(input int i);
    longint tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    return tab[i];
  endfunction

  function automatic longint fshift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint div_near(input longint num, input longint den);
    longint mag;
    longint r;
    mag = (num < 0) ? -num : num;
    r = (mag + den / 2) / den;
    return (num < 0) ? -r : r;
  endfunction

  function automatic longint isqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [15:0] to_q14(input longint v);
    longint lim;
    lim = 64'sd1 <<< FRAC;
    v = rshift(v, 30 - FRAC);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic aarm_pkg::result_t rodrigues(input aarm_pkg::item_t w);
    longint a[3], u[3], r[3][3];
    longint m, z, x, y, c, s, t, dx, dy, l2, sq, qjk, sx, sy, sz;
    bit flip;
    aarm_pkg::result_t o;
    a[0] = longint'(w.axis_x);
    a[1] = longint'(w.axis_y);
    a[2] = longint'(w.axis_z);
    flip = 1'b0;
    m = longint'(w.angle_deg) % 92160;
    if (m < 0) m += 92160;
    if (m >= 46080) m -= 92160;
    if (m > 23040) begin
      m -= 46080;
      flip = 1'b1;
    end else if (m < -23040) begin
      m += 46080;
      flip = 1'b1;
    end
    z = div_near(m * PI_Q30, 46080);
    x = KINV_Q30;
    y = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    l2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    if (l2 == 0) begin
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++) r[j][k] = (j == k) ? ONE_Q30 : 0;
    end else begin
      sq = isqrt(longint'(l2) << 30);
      for (int k = 0; k < 3; k++) u[k] = div_near(a[k] * (64'sd1 <<< 45), sq);
      t = ONE_Q30 - c;
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++) begin
          qjk = div_near((a[j] * a[k]) * ONE_Q30, l2);
          r[j][k] = rshift(t * qjk, 30) + ((j == k) ? c : 0);
        end
      sx = rshift(s * u[0], 30);
      sy = rshift(s * u[1], 30);
      sz = rshift(s * u[2], 30);
      r[0][1] -= sz; r[1][0] += sz;
      r[0][2] += sy; r[2][0] -= sy;
      r[1][2] -= sx; r[2][1] += sx;
    end
    o.row0_col0 = to_q14(r[0][0]);
    o.row0_col1 = to_q14(r[0][1]);
    o.row0_col2 = to_q14(r[0][2]);
    o.row1_col0 = to_q14(r[1][0]);
    o.row1_col1 = to_q14(r[1][1]);
    o.row1_col2 = to_q14(r[1][2]);
    o.row2_col0 = to_q14(r[2][0]);
    o.row2_col1 = to_q14(r[2][1]);
    o.row2_col2 = to_q14(r[2][2]);
    o.axis_is_zero = (l2 == 0);
    return o;
  endfunction

  task automatic report(input string what, input int got, input int want);
    n_errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // random idle gaps before some words
  task automatic send_word(input aarm_pkg::item_t w);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    matrix_queue.push_back(rodrigues(w));
    @(negedge clk);
  endtask

  task automatic send_axis(input int ax, input int ay, input int az, input int ang);
    aarm_pkg::item_t w;
    w.axis_x = 16'(ax);
    w.axis_y = 16'(ay);
    w.axis_z = 16'(az);
    w.angle_deg = 20'(ang);
    send_word(w);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(negedge clk);
    while (matrix_queue.size() != 0) @(negedge clk);
  endtask

  task automatic test_zero_axis();
    send_axis(0, 0, 0, 0);
    send_axis(0, 0, 0, 23040);
    send_axis(0, 0, 0, -524288);
  endtask

  task automatic test_field_extremes();
    send_axis(32767, 32767, 32767, 524287);
    send_axis(-32768, -32768, -32768, -524288);
    send_axis(-32768, 0, 0, 11520);
    send_axis(0, 32767, 0, -11520);
    send_axis(0, 0, -32768, 46080);
    send_axis(1, 0, 0, 1);
    send_axis(0, -1, 0, -1);
    send_axis(0, 0, 1, 92160);
    send_axis(-32768, 32767, 1, 0);
  endtask

  task automatic test_angle_wrap();
    int angles[10] = '{23040, 23041, -23040, -23041, 46079, -46080, 69120,
                        92159, -92160, 300000};
    foreach (angles[i]) send_axis(3, -4, 12, angles[i]);
  endtask

  task automatic test_random();
    aarm_pkg::item_t w;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) drain();
      if (n == N_RANDOM - 200) calm = 1'b1;
      w = aarm_pkg::item_t'(68'({$urandom, $urandom, $urandom}));
      case ($urandom_range(0, 7))
        0: begin
          w.axis_x = 16'($signed($urandom_range(0, 6)) - 3);
          w.axis_y = 16'($signed($urandom_range(0, 6)) - 3);
          w.axis_z = 16'($signed($urandom_range(0, 6)) - 3);
        end
        1: w.angle_deg = 20'(int'($urandom_range(0, 8)) * 11520 - 46080);
        2: begin
          w.axis_x = '0; w.axis_y = '0; w.axis_z = '0;
        end
        default: ;
      endcase
      send_word(w);
    end
  endtask

  // result side: random stall bursts, in-order compare
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (calm) result_stall <= 1'b0;
      else if (burst > 0) begin
        burst--;
        result_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 14);
        result_stall <= 1'b1;
      end else result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    aarm_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (matrix_queue.size() == 0) report("unexpected word", 0, 0);
      else begin
        want = matrix_queue.pop_front();
        n_matrices++;
        if (want.axis_is_zero) n_zero_axis++;
        if (result.row0_col0 !== want.row0_col0)
          report("r00", int'(result.row0_col0), int'(want.row0_col0));
        if (result.row0_col1 !== want.row0_col1)
          report("r01", int'(result.row0_col1), int'(want.row0_col1));
        if (result.row0_col2 !== want.row0_col2)
          report("r02", int'(result.row0_col2), int'(want.row0_col2));
        if (result.row1_col0 !== want.row1_col0)
          report("r10", int'(result.row1_col0), int'(want.row1_col0));
        if (result.row1_col1 !== want.row1_col1)
          report("r11", int'(result.row1_col1), int'(want.row1_col1));
        if (result.row1_col2 !== want.row1_col2)
          report("r12", int'(result.row1_col2), int'(want.row1_col2));
        if (result.row2_col0 !== want.row2_col0)
          report("r20", int'(result.row2_col0), int'(want.row2_col0));
        if (result.row2_col1 !== want.row2_col1)
          report("r21", int'(result.row2_col1), int'(want.row2_col1));
        if (result.row2_col2 !== want.row2_col2)
          report("r22", int'(result.row2_col2), int'(want.row2_col2));
        if (result.axis_is_zero !== want.axis_is_zero)
          report("axis_is_zero", int'(result.axis_is_zero), int'(want.axis_is_zero));
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_zero_axis();
    test_field_extremes();
    test_angle_wrap();
    test_random();
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (matrix_queue.size() != 0) report("words left over", matrix_queue.size(), 0);
    $display("checked %0d matrices, %0d with a zero axis, angles wrapped over the full range",
             n_matrices, n_zero_axis);
    if (n_errors == 0) $display("[axis_angle_rotation_matrix] OK");
    else $display("[axis_angle_rotation_matrix] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[axis_angle_rotation_matrix] ERROR");
    $finish;
  end

endmodule
